/* hdl/assert_macros.svh */
// Assertion macros used by the checked RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/wti_pkg.sv */
// Types and constants of the waypoint trajectory interpolator.
package wti_pkg;
   localparam int MAX_POINTS  = 64;
   localparam int JOINT_COUNT = 6;
   localparam int ADDR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int JOINT_W     = 16;
   localparam int TIME_W      = 32;
   localparam int ROW_W       = JOINT_COUNT * JOINT_W;
   localparam int JIDX_W      = $clog2(JOINT_COUNT);
   localparam int ELAP_W      = TIME_W + 1;
   localparam int QUO_W       = JOINT_W + 1;
   localparam int DEN_W       = TIME_W + 2;
   localparam int NUM_W       = DEN_W + QUO_W;
   localparam int MUL_A_W     = TIME_W + 1;
   localparam int MUL_B_W     = JOINT_W + 2;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_TICK = 2'd1,
      REQ_STOP = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic [TIME_W-1:0]         wp_time;
      logic signed [JOINT_W-1:0] wp_joint_0;
      logic signed [JOINT_W-1:0] wp_joint_1;
      logic signed [JOINT_W-1:0] wp_joint_2;
      logic signed [JOINT_W-1:0] wp_joint_3;
      logic signed [JOINT_W-1:0] wp_joint_4;
      logic signed [JOINT_W-1:0] wp_joint_5;
      logic                      wp_last;
      logic [TIME_W-1:0]         now_time;
   } req_payload_type;

   typedef struct packed {
      logic                      valid_res;
      logic signed [JOINT_W-1:0] joint_0;
      logic signed [JOINT_W-1:0] joint_1;
      logic signed [JOINT_W-1:0] joint_2;
      logic signed [JOINT_W-1:0] joint_3;
      logic signed [JOINT_W-1:0] joint_4;
      logic signed [JOINT_W-1:0] joint_5;
      logic                      still_active;
   } rsp_payload_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numerator;
      logic [DEN_W-1:0] denominator;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;
endpackage

/* hdl/wti_channels.sv */
// Valid/ready channel interfaces for requests and responses.
interface req_chan_if;
   import wti_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rsp_chan_if;
   import wti_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/waypoint_trajectory_interpolator.sv */
// Top level: waypoint store, tick sequencer, multiplier and shared divider.
// A load or stop transaction is taken while ready stays high, so they run back to back.
// An interpolating tick keeps ready low while it steps past the waypoints already reached, reads
// the segment, then per joint runs multiply, sum and the 17-step divider before it responds.
// A tick at the last waypoint returns that point, a zero-length segment its end point, a disarmed
// tick an invalid result; a stalled response holds it. Synchronous reset disarms, no clearing.
`include "assert_macros.svh"
module waypoint_trajectory_interpolator (
   input logic        clock,
   input logic        reset,
   req_chan_if.sink   req_chan,
   rsp_chan_if.source rsp_chan
);
   import wti_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADV_RD, ST_ADV_CMP, ST_SEG_RD0, ST_SEG_RD1, ST_SEG_CAP, ST_SEG_CALC,
      ST_MUL_A, ST_MUL_B, ST_SUM, ST_DIV_SETUP, ST_DIV_WAIT, ST_LAST_RD, ST_LAST_CAP,
      ST_FINISH
   } state_type;

   state_type                    state_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [ADDR_W-1:0]            seg_ff;
   logic                         running_ff, started_ff, loading_ff;
   logic [TIME_W-1:0]            start_ff;
   logic signed [ELAP_W-1:0]     elapsed_ff;
   logic [TIME_W-1:0]            t0_ff, dt_ff, n_ff;
   logic                         dt_pos_ff;
   logic signed [ELAP_W:0]       nraw_ff;
   logic [ROW_W-1:0]             j0_row_ff, j1_row_ff;
   logic [JIDX_W-1:0]            jidx_ff;
   logic signed [PROD_W-1:0]     acc_ff, prod_ff, sum_ff;
   logic                         neg_ff;
   logic [JOINT_W-1:0]           res_ff [JOINT_COUNT];
   logic                         res_valid_ff, res_active_ff;
   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_data_ff;
   div_ctl_type                  div_ctl_ff;
   div_stat_type                 div_stat;

   logic                         req_fire;
   logic [CNT_W-1:0]             seg_next1, last_cnt, base_cnt, new_cnt;
   logic [ADDR_W-1:0]            rd_addr;
   logic                         wr_en;
   logic [TIME_W-1:0]            rd_time;
   logic [ROW_W-1:0]             rd_row, wr_row;
   logic signed [ELAP_W-1:0]     dt_s;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     product;
   logic signed [MUL_B_W-1:0]    j0_x, j1_x;
   logic [PROD_W-1:0]            mag;
   logic [QUO_W-1:0]             signed_q;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign seg_next1 = {1'b0, seg_ff} + CNT_W'(1);
   assign last_cnt  = count_ff - CNT_W'(1);
   assign base_cnt  = loading_ff ? count_ff : '0;
   assign wr_en     = req_fire && (req_chan.payload.req_type == REQ_LOAD)
                      && (base_cnt < CNT_W'(MAX_POINTS));
   assign new_cnt   = wr_en ? base_cnt + CNT_W'(1) : base_cnt;
   assign wr_row    = {req_chan.payload.wp_joint_5, req_chan.payload.wp_joint_4,
                       req_chan.payload.wp_joint_3, req_chan.payload.wp_joint_2,
                       req_chan.payload.wp_joint_1, req_chan.payload.wp_joint_0};

   always_comb begin
      case (state_ff)
         ST_SEG_RD0: rd_addr = seg_ff;
         ST_LAST_RD: rd_addr = last_cnt[ADDR_W-1:0];
         default:    rd_addr = seg_next1[ADDR_W-1:0];
      endcase
   end

   wti_ram #(.WIDTH(TIME_W), .DEPTH(MAX_POINTS)) u_time_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(base_cnt[ADDR_W-1:0]),
      .wr_data(req_chan.payload.wp_time), .rd_addr(rd_addr), .rd_data(rd_time)
   );

   wti_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_joint_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(base_cnt[ADDR_W-1:0]),
      .wr_data(wr_row), .rd_addr(rd_addr), .rd_data(rd_row)
   );

   wti_divider u_divider (.clock(clock), .reset(reset), .ctl(div_ctl_ff), .stat(div_stat));

   assign dt_s = $signed({1'b0, rd_time}) - $signed({1'b0, t0_ff});
   assign j0_x = MUL_B_W'($signed(j0_row_ff[jidx_ff*JOINT_W +: JOINT_W]));
   assign j1_x = MUL_B_W'($signed(j1_row_ff[jidx_ff*JOINT_W +: JOINT_W]));

   // The multiplier forms j0*dt first and n*(j1-j0) in the following cycle.
   always_comb begin
      if (state_ff == ST_MUL_A) begin
         mul_a = $signed({1'b0, dt_ff});
         mul_b = j0_x;
      end else begin
         mul_a = $signed({1'b0, n_ff});
         mul_b = j1_x - j0_x;
      end
   end
   assign product = mul_a * mul_b;

   assign mag      = sum_ff[PROD_W-1] ? PROD_W'(-sum_ff) : PROD_W'(sum_ff);
   assign signed_q = neg_ff ? QUO_W'(-div_stat.quotient) : div_stat.quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         seg_ff       <= '0;
         running_ff   <= 1'b0;
         started_ff   <= 1'b0;
         loading_ff   <= 1'b0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_ctl_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_chan.payload.req_type)
                     REQ_LOAD: begin
                        // A load outside a list opens a fresh list; every load disarms but the last one of a list.
                        count_ff   <= new_cnt;
                        loading_ff <= !req_chan.payload.wp_last;
                        if (!loading_ff || req_chan.payload.wp_last) begin
                           seg_ff     <= '0;
                           started_ff <= 1'b0;
                        end
                        running_ff <= req_chan.payload.wp_last && (new_cnt != '0);
                     end
                     REQ_TICK: begin
                        for (int k = 0; k < JOINT_COUNT; k++) begin
                           res_ff[k] <= '0;
                        end
                        res_valid_ff  <= 1'b0;
                        res_active_ff <= 1'b0;
                        if (!running_ff || count_ff == '0) begin
                           state_ff <= ST_FINISH;
                        end else begin
                           if (!started_ff) begin
                              start_ff   <= req_chan.payload.now_time;
                              started_ff <= 1'b1;
                              elapsed_ff <= '0;
                           end else begin
                              elapsed_ff <= $signed({1'b0, req_chan.payload.now_time})
                                            - $signed({1'b0, start_ff});
                           end
                           state_ff <= ST_ADV_RD;
                        end
                     end
                     REQ_STOP: begin
                        running_ff <= 1'b0;
                        loading_ff <= 1'b0;
                        started_ff <= 1'b0;
                        count_ff   <= '0;
                        seg_ff     <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_ADV_RD: begin
               state_ff <= (seg_next1 < count_ff) ? ST_ADV_CMP : ST_LAST_RD;
            end
            ST_ADV_CMP: begin
               if ($signed({1'b0, rd_time}) <= elapsed_ff) begin
                  seg_ff   <= seg_next1[ADDR_W-1:0];
                  state_ff <= ST_ADV_RD;
               end else begin
                  state_ff <= ST_SEG_RD0;
               end
            end
            ST_SEG_RD0: state_ff <= ST_SEG_RD1;
            ST_SEG_RD1: begin
               t0_ff     <= rd_time;
               j0_row_ff <= rd_row;
               state_ff  <= ST_SEG_CAP;
            end
            ST_SEG_CAP: begin
               j1_row_ff <= rd_row;
               dt_ff     <= dt_s[TIME_W-1:0];
               dt_pos_ff <= !dt_s[ELAP_W-1] && (dt_s != '0);
               nraw_ff   <= {elapsed_ff[ELAP_W-1], elapsed_ff} - $signed({2'b00, t0_ff});
               state_ff  <= ST_SEG_CALC;
            end
            ST_SEG_CALC: begin
               if (nraw_ff[ELAP_W]) begin
                  n_ff <= '0;
               end else if (nraw_ff > $signed({2'b00, dt_ff})) begin
                  n_ff <= dt_ff;
               end else begin
                  n_ff <= nraw_ff[TIME_W-1:0];
               end
               jidx_ff <= '0;
               if (dt_pos_ff) begin
                  state_ff <= ST_MUL_A;
               end else begin
                  // A segment of zero or negative length jumps to its end point.
                  for (int k = 0; k < JOINT_COUNT; k++) begin
                     res_ff[k] <= j1_row_ff[k*JOINT_W +: JOINT_W];
                  end
                  res_valid_ff  <= 1'b1;
                  res_active_ff <= 1'b1;
                  state_ff      <= ST_FINISH;
               end
            end
            ST_MUL_A: begin
               acc_ff   <= product;
               state_ff <= ST_MUL_B;
            end
            ST_MUL_B: begin
               prod_ff  <= product;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff   <= acc_ff + prod_ff;
               state_ff <= ST_DIV_SETUP;
            end
            ST_DIV_SETUP: begin
               // Rounding away from zero: (2|p| + dt) / (2 dt), sign applied after.
               neg_ff                 <= sum_ff[PROD_W-1];
               div_ctl_ff.start       <= 1'b1;
               div_ctl_ff.numerator   <= NUM_W'({mag, 1'b0}) + NUM_W'(dt_ff);
               div_ctl_ff.denominator <= {1'b0, dt_ff, 1'b0};
               state_ff               <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               div_ctl_ff.start <= 1'b0;
               if (div_stat.done) begin
                  res_ff[jidx_ff] <= signed_q[JOINT_W-1:0];
                  if (jidx_ff == JIDX_W'(JOINT_COUNT - 1)) begin
                     res_valid_ff  <= 1'b1;
                     res_active_ff <= 1'b1;
                     state_ff      <= ST_FINISH;
                  end else begin
                     jidx_ff  <= jidx_ff + 1'b1;
                     state_ff <= ST_MUL_A;
                  end
               end
            end
            ST_LAST_RD: state_ff <= ST_LAST_CAP;
            ST_LAST_CAP: begin
               for (int k = 0; k < JOINT_COUNT; k++) begin
                  res_ff[k] <= rd_row[k*JOINT_W +: JOINT_W];
               end
               res_valid_ff  <= 1'b1;
               res_active_ff <= 1'b0;
               running_ff    <= 1'b0;
               state_ff      <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.valid_res     <= res_valid_ff;
                  rsp_data_ff.joint_0       <= res_ff[0];
                  rsp_data_ff.joint_1       <= res_ff[1];
                  rsp_data_ff.joint_2       <= res_ff[2];
                  rsp_data_ff.joint_3       <= res_ff[3];
                  rsp_data_ff.joint_4       <= res_ff[4];
                  rsp_data_ff.joint_5       <= res_ff[5];
                  rsp_data_ff.still_active  <= res_active_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS))
   `ASSERT_IMPLIES(a_seg_in_list, clock, reset, running_ff && state_ff == ST_IDLE,
                   {1'b0, seg_ff} < count_ff)
   `ASSERT_IMPLIES(a_load_disarmed, clock, reset, loading_ff, !running_ff)
   `ASSERT_NEXT(a_tick_busy, clock, reset,
                req_fire && req_chan.payload.req_type == REQ_TICK,
                state_ff != ST_IDLE)
endmodule

/* hdl/wti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/wti_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module wti_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wti_pkg::div_ctl_type ctl,
   output wti_pkg::div_stat_type stat
);
   import wti_pkg::*;

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  low_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] steps_ff;
   logic              done_ff;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    trial;

   assign shifted = {rem_ff, low_ff[QUO_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            // The quotient fits QUO_W bits, so the top part is already below the divisor.
            rem_ff   <= ctl.numerator[NUM_W-1:QUO_W];
            low_ff   <= ctl.numerator[QUO_W-1:0];
            den_ff   <= ctl.denominator;
            quo_ff   <= '0;
            steps_ff <= STEP_W'(QUO_W);
         end else if (steps_ff != '0) begin
            if (!trial[DEN_W]) begin
               rem_ff <= trial[DEN_W-1:0];
            end else begin
               rem_ff <= shifted[DEN_W-1:0];
            end
            quo_ff   <= {quo_ff[QUO_W-2:0], ~trial[DEN_W]};
            low_ff   <= {low_ff[QUO_W-2:0], 1'b0};
            steps_ff <= steps_ff - 1'b1;
            done_ff  <= (steps_ff == STEP_W'(1));
         end
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;
endmodule

/* tb/testbench.sv */
// Testbench of the waypoint trajectory interpolator: random and directed traffic with a scoreboard.
module testbench;
   import wti_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int HOLD_CYCLES    = 500;
   localparam int ITEM_TARGET    = 1500;

   // Tracks the waypoint list the way the block should and keeps pending tick responses.
   class trajectory_scoreboard;
      logic [TIME_W-1:0]         wp_times[MAX_POINTS];
      logic signed [JOINT_W-1:0] wp_joints[MAX_POINTS][JOINT_COUNT];
      int unsigned               count;
      int unsigned               seg;
      bit                        armed;
      bit                        stamped;
      bit                        filling;
      logic [TIME_W-1:0]         stamp;
      rsp_payload_type           pending[$];
      int                        mismatches;

      function new();
         count = 0; seg = 0; armed = 0; stamped = 0; filling = 0; stamp = '0;
         mismatches = 0;
      endfunction

      function automatic longint round_div(longint p, longint q);
         if (p >= 0) return (2 * p + q) / (2 * q);
         return -((-2 * p + q) / (2 * q));
      endfunction

      function automatic rsp_payload_type tick_result(logic [TIME_W-1:0] now);
         rsp_payload_type r;
         logic signed [JOINT_W-1:0] pos[JOINT_COUNT];
         longint elapsed, t0, dt, n, j0, j1;
         int unsigned a;
         r = '0;
         if (!armed || count == 0) return r;
         if (!stamped) begin
            stamp = now;
            stamped = 1;
         end
         elapsed = longint'(now) - longint'(stamp);
         while (seg + 1 < count && longint'(wp_times[seg + 1]) <= elapsed) seg++;
         r.valid_res = 1;
         if (seg + 1 >= count) begin
            for (int j = 0; j < JOINT_COUNT; j++) pos[j] = wp_joints[count - 1][j];
            armed = 0;
            r.still_active = 0;
         end else begin
            a = seg;
            t0 = longint'(wp_times[a]);
            dt = longint'(wp_times[a + 1]) - t0;
            n = elapsed - t0;
            if (n < 0) n = 0;
            if (dt > 0 && n > dt) n = dt;
            for (int j = 0; j < JOINT_COUNT; j++) begin
               j0 = wp_joints[a][j];
               j1 = wp_joints[a + 1][j];
               if (dt <= 0) pos[j] = j1[JOINT_W-1:0];
               else pos[j] = JOINT_W'(round_div(j0 * dt + n * (j1 - j0), dt));
            end
            r.still_active = 1;
         end
         r.joint_0 = pos[0]; r.joint_1 = pos[1]; r.joint_2 = pos[2];
         r.joint_3 = pos[3]; r.joint_4 = pos[4]; r.joint_5 = pos[5];
         return r;
      endfunction

      function void note_request(req_payload_type p);
         case (p.req_type)
            REQ_LOAD: begin
               if (!filling) begin
                  count = 0; seg = 0; armed = 0; stamped = 0; filling = 1;
               end
               if (count < MAX_POINTS) begin
                  wp_times[count] = p.wp_time;
                  wp_joints[count][0] = p.wp_joint_0;
                  wp_joints[count][1] = p.wp_joint_1;
                  wp_joints[count][2] = p.wp_joint_2;
                  wp_joints[count][3] = p.wp_joint_3;
                  wp_joints[count][4] = p.wp_joint_4;
                  wp_joints[count][5] = p.wp_joint_5;
                  count++;
               end
               if (p.wp_last) begin
                  filling = 0; seg = 0; stamped = 0;
                  armed = count > 0;
               end
            end
            REQ_TICK: pending.push_back(tick_result(p.now_time));
            REQ_STOP: begin
               armed = 0; filling = 0; stamped = 0; count = 0; seg = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   req_chan_if req_chan();
   rsp_chan_if rsp_chan();

   waypoint_trajectory_interpolator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   trajectory_scoreboard board = new();
   int  items_sent = 0;
   bit  quiet = 0;
   bit  hold_request = 0;
   bit  held = 0;
   bit  drained = 0;
   int  idle_cycles = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.payload = '0;
      rsp_chan.ready = 0;
   end

   // Response side: random stalls, one long hold-off on request.
   initial begin
      @(posedge clock);
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_chan.ready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) board.check_response(rsp_chan.payload);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("waypoint_trajectory_interpolator verification failed");
         $finish;
      end
   end

   task automatic send(input req_payload_type p);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.payload <= p;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(p);
      items_sent++;
   endtask

   task automatic send_load(input logic [TIME_W-1:0] t, input logic [ROW_W-1:0] row,
                            input logic last);
      req_payload_type p;
      p = '0;
      p.req_type = REQ_LOAD;
      p.wp_time = t;
      {p.wp_joint_0, p.wp_joint_1, p.wp_joint_2,
       p.wp_joint_3, p.wp_joint_4, p.wp_joint_5} = row;
      p.wp_last = last;
      p.now_time = $urandom;
      send(p);
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      req_payload_type p;
      p = '0;
      p.req_type = REQ_TICK;
      p.now_time = now;
      p.wp_time = $urandom;
      send(p);
   endtask

   task automatic send_code(input logic [1:0] code);
      req_payload_type p;
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(req_payload_type)-1:0];
      p.req_type = code;
      send(p);
   endtask

   function automatic logic [ROW_W-1:0] random_row();
      return {$urandom, $urandom, $urandom};
   endfunction

   task automatic drain();
      req_chan.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One list of waypoints followed by ticks walking through it.
   task automatic random_trajectory();
      int npts, nticks;
      logic [TIME_W-1:0] t, now;
      int r;
      r = $urandom_range(0, 99);
      npts = (r < 3) ? $urandom_range(60, 70) : (r < 8) ? 1 : $urandom_range(2, 6);
      t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20);
      for (int i = 0; i < npts; i++) begin
         send_load(t, random_row(), i == npts - 1);
         case ($urandom_range(0, 9))
            0: t = t - $urandom_range(0, 20);
            1: ;
            2: t = $urandom;
            default: t = t + $urandom_range(1, 60);
         endcase
      end
      now = $urandom;
      nticks = $urandom_range(2, 12);
      for (int i = 0; i < nticks; i++) begin
         send_tick(now);
         if ($urandom_range(0, 9) == 0) now = now - $urandom_range(0, 30);
         else if ($urandom_range(0, 19) == 0) now = $urandom;
         else now = now + $urandom_range(0, 80);
         if ($urandom_range(0, 29) == 0) send_code(REQ_STOP);
      end
   endtask

   initial begin
      logic [ROW_W-1:0] lo, hi;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: tick while disarmed, extremes, zero and negative segments,
      // clock going back, tick while loading, stop, unknown code, full store.
      lo = {6{16'sh8000}};
      hi = {6{16'sh7fff}};
      send_tick(32'hffff_ffff);
      send_load(0, lo, 1'b0);
      send_tick(5);
      send_load(100, hi, 1'b0);
      send_load(100, lo, 1'b0);
      send_load(32'hffff_ffff, hi, 1'b0);
      send_load(50, random_row(), 1'b1);
      send_tick(32'hffff_fff0);
      send_tick(32'hffff_fff0 + 50);
      send_tick(32'hffff_fff0 + 25);
      send_tick(32'hffff_fff0 + 100);
      send_tick(32'hffff_fff0 + 101);
      send_code(2'd3);
      send_load(0, hi, 1'b0);
      send_load(3, lo, 1'b1);
      send_tick(0);
      send_tick(1);
      send_code(REQ_STOP);
      send_tick(2);
      for (int i = 0; i < MAX_POINTS + 3; i++)
         send_load(i * 2, random_row(), i == MAX_POINTS + 2);
      send_tick(1000);
      send_tick(1000 + MAX_POINTS);
      send_tick(1000 + 4 * MAX_POINTS);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent > 400 && !held) begin
            hold_request = 1;
            held = 1;
         end
         if (items_sent > 800 && !drained) begin
            drain();
            drained = 1;
         end
         if (items_sent > ITEM_TARGET - 200) quiet = 1;
         if ($urandom_range(0, 9) == 0) send_code(2'($urandom_range(0, 3)));
         else random_trajectory();
      end
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("waypoint_trajectory_interpolator verification clean");
      else
         $display("waypoint_trajectory_interpolator verification failed");
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/wti_pkg.sv
hdl/wti_channels.sv
hdl/wti_ram.sv
hdl/wti_divider.sv
hdl/waypoint_trajectory_interpolator.sv
tb/testbench.sv
